### src/cocktail_shaker_sorter_macros.svh
// Assertion macros for the cocktail shaker sorter.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef COCKTAIL_SHAKER_SORTER_MACROS_SVH
`define COCKTAIL_SHAKER_SORTER_MACROS_SVH

// Checked on every rising edge outside reset.
`define CSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define CSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### src/css_pkg.sv
// Shared types and constants of the cocktail shaker sorter.
// No dependencies.
`timescale 1ns / 1ps

package css_pkg;

  localparam int DEPTH   = 32;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [AW-1:0]      addr_t;
  typedef logic [CW-1:0]      count_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_START,
    ST_RUN,
    ST_FLUSH,
    ST_DRAIN
  } ctrl_state_e;

  typedef enum logic [1:0] {
    WR_INPUT,
    WR_CMP,
    WR_CARRY
  } wr_sel_e;

  // the store traffic of the current cycle, issued by the sequencer
  typedef struct packed {
    logic    rd_en;
    addr_t   rd_addr;
    logic    wr_en;
    addr_t   wr_addr;
    wr_sel_e wr_sel;
    logic    load_carry;
    logic    cmp_step;
    logic    dir_bwd;
  } mem_op_t;

endpackage

### src/css_in_if.sv
// Input channel of the sorter: one value per transfer, last closes the set.
// Depends on css_pkg.
`timescale 1ns / 1ps

interface css_in_if;
  logic            valid;
  logic            ready;
  css_pkg::value_t value;
  logic            last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

### src/css_out_if.sv
// Result channel of the sorter: sorted values with run markers.
// Depends on css_pkg.
`timescale 1ns / 1ps

interface css_out_if;
  logic            valid;
  logic            ready;
  css_pkg::value_t sorted_value;
  logic            last_out;
  logic            truncated;

  modport source (output valid, output sorted_value, output last_out, output truncated,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input truncated,
                  output ready);
endinterface

### src/css_dp.sv
// Datapath: element store, registered read port, carry register, comparator.
// Depends on css_pkg.
`timescale 1ns / 1ps

module css_dp (
  input  logic             clk_i,
  input  css_pkg::value_t  in_value_i,
  input  css_pkg::mem_op_t mem_op_i,
  output css_pkg::value_t  rdata_o
);
  import css_pkg::*;

  value_t store_q [DEPTH];
  value_t rdata_q;
  value_t carry_q;
  value_t carry_d;
  value_t min_v;
  value_t max_v;
  value_t wdata;

  // carry holds the element moving along the chain
  always_comb begin
    if (carry_q < rdata_q) begin
      min_v = carry_q;
      max_v = rdata_q;
    end else begin
      min_v = rdata_q;
      max_v = carry_q;
    end
  end

  // lower index keeps the minimum in both directions
  always_comb begin
    case (mem_op_i.wr_sel)
      WR_INPUT: wdata = in_value_i;
      WR_CMP:   wdata = mem_op_i.dir_bwd ? max_v : min_v;
      WR_CARRY: wdata = carry_q;
      default:  wdata = carry_q;
    endcase
  end

  always_comb begin
    carry_d = carry_q;
    if (mem_op_i.load_carry) begin
      carry_d = rdata_q;
    end else if (mem_op_i.cmp_step) begin
      carry_d = mem_op_i.dir_bwd ? min_v : max_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_op_i.wr_en) begin
      store_q[mem_op_i.wr_addr] <= wdata;
    end
    if (mem_op_i.rd_en) begin
      rdata_q <= store_q[mem_op_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
  end

  assign rdata_o = rdata_q;

endmodule

### src/css_ctrl.sv
// Sequencer: fill count, shaker pass bounds, chain walk and output drain.
// Depends on css_pkg and cocktail_shaker_sorter_macros.svh.
`timescale 1ns / 1ps

module css_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             out_last_o,
  output logic             out_trunc_o,
  output css_pkg::mem_op_t mem_op_o
);
  import css_pkg::*;
  `include "cocktail_shaker_sorter_macros.svh"

  localparam logic [AW:0] GAP_WIDE   = (AW + 1)'(2);
  localparam logic [AW:0] GAP_NARROW = (AW + 1)'(1);

  ctrl_state_e state_q, state_d;
  count_t      fill_q, fill_d;
  logic        ovf_q, ovf_d;
  count_t      idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  logic        out_last_q, out_last_d;
  logic        out_trunc_q, out_trunc_d;
  logic        g2_q, g2_d;
  logic        dir_q, dir_d;
  logic        first_q, first_d;
  addr_t       lo_q, lo_d;
  addr_t       hi_q, hi_d;
  addr_t       cur_q, cur_d;
  addr_t       pos_q, pos_d;
  mem_op_t     op;

  logic [AW:0] gap;
  logic [AW:0] lo_ext;
  logic [AW:0] hi_ext;
  logic [AW:0] cur_ext;
  logic [AW:0] fwd_next;
  logic [AW:0] bwd_next;
  logic        next_ok;
  logic        round_ok;
  logic        fill_full;
  count_t      fill_after;
  logic        can_load;

  assign gap      = g2_q ? GAP_WIDE : GAP_NARROW;
  assign lo_ext   = {1'b0, lo_q};
  assign hi_ext   = {1'b0, hi_q};
  assign cur_ext  = {1'b0, cur_q};
  assign fwd_next = cur_ext + gap;
  assign bwd_next = cur_ext - gap;
  assign next_ok  = dir_q ? (cur_ext >= lo_ext + gap) : (fwd_next <= hi_ext);
  assign round_ok = (lo_ext + gap) <= hi_ext;

  assign fill_full  = (fill_q == CW'(DEPTH));
  assign fill_after = fill_full ? fill_q : fill_q + CW'(1);
  assign can_load   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_trunc_d = out_trunc_q;
    g2_d        = g2_q;
    dir_d       = dir_q;
    first_d     = first_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    cur_d       = cur_q;
    pos_d       = pos_q;
    op          = '0;
    op.wr_sel   = WR_CMP;
    op.dir_bwd  = dir_q;
    in_ready_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (fill_full) begin
            ovf_d = 1'b1;
          end else begin
            op.wr_en   = 1'b1;
            op.wr_addr = fill_q[AW-1:0];
            op.wr_sel  = WR_INPUT;
            fill_d     = fill_after;
          end
          if (in_last_i) begin
            idx_d = '0;
            if (fill_after < CW'(2)) begin
              state_d = ST_DRAIN;
            end else begin
              g2_d    = 1'b1;
              dir_d   = 1'b0;
              lo_d    = '0;
              hi_d    = AW'(fill_after - CW'(1));
              state_d = ST_CHECK;
            end
          end
        end
      end

      ST_CHECK: begin
        if (round_ok) begin
          dir_d   = 1'b0;
          state_d = ST_START;
        end else if (g2_q) begin
          // gap-2 rounds done, restart bounds for the full gap-1 sort
          g2_d = 1'b0;
          lo_d = '0;
          hi_d = AW'(fill_q - CW'(1));
        end else begin
          state_d = ST_DRAIN;
        end
      end

      ST_START: begin
        op.rd_en   = 1'b1;
        op.rd_addr = dir_q ? hi_q : lo_q;
        cur_d      = dir_q ? hi_q : lo_q;
        first_d    = 1'b1;
        state_d    = ST_RUN;
      end

      ST_RUN: begin
        if (first_q) begin
          op.load_carry = 1'b1;
        end else begin
          op.wr_en    = 1'b1;
          op.wr_addr  = pos_q;
          op.cmp_step = 1'b1;
        end
        first_d = 1'b0;
        pos_d   = cur_q;
        if (next_ok) begin
          op.rd_en   = 1'b1;
          op.rd_addr = dir_q ? bwd_next[AW-1:0] : fwd_next[AW-1:0];
          cur_d      = op.rd_addr;
        end else begin
          state_d = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        op.wr_en   = 1'b1;
        op.wr_addr = pos_q;
        op.wr_sel  = WR_CARRY;
        if (dir_q) begin
          lo_d    = AW'(lo_ext + gap);
          dir_d   = 1'b0;
          state_d = ST_CHECK;
        end else begin
          hi_d    = AW'(hi_ext - gap);
          dir_d   = 1'b1;
          state_d = ST_START;
        end
      end

      ST_DRAIN: begin
        if (can_load) begin
          if (idx_q < fill_q) begin
            op.rd_en    = 1'b1;
            op.rd_addr  = idx_q[AW-1:0];
            out_valid_d = 1'b1;
            out_last_d  = (idx_q + CW'(1)) == fill_q;
            out_trunc_d = ovf_q;
            idx_d       = idx_q + CW'(1);
          end else begin
            out_valid_d = 1'b0;
            fill_d      = '0;
            ovf_d       = 1'b0;
            idx_d       = '0;
            state_d     = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_trunc_q <= 1'b0;
      g2_q        <= 1'b0;
      dir_q       <= 1'b0;
      first_q     <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      cur_q       <= '0;
      pos_q       <= '0;
    end else begin
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      out_trunc_q <= out_trunc_d;
      g2_q        <= g2_d;
      dir_q       <= dir_d;
      first_q     <= first_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      cur_q       <= cur_d;
      pos_q       <= pos_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_trunc_o = out_trunc_q;
  assign mem_op_o    = op;

  `CSS_ASSERT(a_no_rw_collide, (op.rd_en && op.wr_en) |-> (op.rd_addr != op.wr_addr), "read and write hit the same entry")
  `CSS_ASSERT_ALWAYS(a_fill_bound, fill_q <= CW'(DEPTH), "fill count beyond store depth")
  `CSS_ASSERT(a_out_in_drain, out_valid_q |-> (state_q == ST_DRAIN), "result shown outside drain")
  `CSS_ASSERT(a_hi_in_set, (state_q != ST_IDLE && state_q != ST_DRAIN) |-> (CW'(hi_q) < fill_q), "pass bound outside the stored set")
  `CSS_ASSERT(a_last_at_end, (out_valid_q && out_last_q) |-> (idx_q == fill_q), "last marker before the final element")

endmodule

### src/cocktail_shaker_sorter.sv
// Cocktail shaker sorter, top level. Loading accepts back-to-back transfers while collecting a set.
// Sort of n stored values: one compare-exchange per cycle while a pass runs, set by the
// single write port of the element store; drain then gives one result per cycle while the
// receiver is ready.
// Reset (async, active low) clears fill count, overflow flag and sequencer; store undefined.
`timescale 1ns / 1ps

module cocktail_shaker_sorter (
  input  logic      clk_i,
  input  logic      rst_ni,
  css_in_if.sink    item_i,
  css_out_if.source result_o
);
  import css_pkg::*;

  // Store traffic from the sequencer. During a pass the datapath walks a
  // chain at stride gap: each cycle it reads the next entry, compares it with
  // the carried element and writes the loser two chain places behind the
  // read, so a read never meets a pending write. Forward passes carry the
  // maximum up, backward passes carry the minimum down; the carry is written
  // back when the chain ends. Gap 2 rounds run first, then gap 1 to the end.
  mem_op_t mem_op;
  value_t  rdata;
  logic    out_valid;
  logic    out_last;
  logic    out_trunc;
  logic    in_ready;

  css_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_last_i   (item_i.last),
    .in_ready_o  (in_ready),
    .out_ready_i (result_o.ready),
    .out_valid_o (out_valid),
    .out_last_o  (out_last),
    .out_trunc_o (out_trunc),
    .mem_op_o    (mem_op)
  );

  // The registered read data doubles as the result payload while draining;
  // it holds while a result is stalled because no read is issued then.
  css_dp u_dp (
    .clk_i      (clk_i),
    .in_value_i (item_i.value),
    .mem_op_i   (mem_op),
    .rdata_o    (rdata)
  );

  // Input transfers are taken only while collecting a set.
  assign item_i.ready          = in_ready;
  assign result_o.valid        = out_valid;
  assign result_o.sorted_value = rdata;
  assign result_o.last_out     = out_last;
  assign result_o.truncated    = out_trunc;

endmodule

### sim/css_sort_checker.sv
// Checker for the cocktail shaker sorter: watches both channels, predicts the sorted bursts
// and compares every result transfer. Depends on css_pkg, css_in_if and css_out_if.
`timescale 1ns / 1ps

module css_sort_checker (
  input  logic clk_i,
  input  logic rst_ni,
  css_in_if    item_ch,
  css_out_if   result_ch,
  output int   fail_count_o,
  output int   pending_o
);
  import css_pkg::*;

  typedef struct packed {
    value_t value;
    logic   last;
    logic   trunc;
  } sorted_entry_t;

  value_t        held_values [DEPTH];
  int            held_count;
  bit            dropped_any;
  sorted_entry_t sorted_q [$];

  initial begin
    held_count   = 0;
    dropped_any  = 1'b0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic void order_pair(input int a, input int b);
    value_t t;
    if (held_values[a] > held_values[b]) begin
      t              = held_values[a];
      held_values[a] = held_values[b];
      held_values[b] = t;
    end
  endfunction

  // bidirectional compare-exchange passes at gap g over entries 0..n-1
  function automatic void shaker_pass(input int n, input int g);
    int lo;
    int hi;
    int i;
    if (n < 2) return;
    lo = 0;
    hi = n - 1;
    while (lo + g <= hi) begin
      for (i = lo; i + g <= hi; i += g) order_pair(i, i + g);
      hi -= g;
      for (i = hi; i >= lo + g; i -= g) order_pair(i - g, i);
      lo += g;
    end
  endfunction

  // close the set: sort what was kept and queue the burst
  function automatic void sort_held_set();
    sorted_entry_t e;
    shaker_pass(held_count, 2);
    shaker_pass(held_count, 1);
    for (int i = 0; i < held_count; i++) begin
      e.value = held_values[i];
      e.last  = (i + 1 == held_count);
      e.trunc = dropped_any;
      sorted_q.push_back(e);
    end
    held_count  = 0;
    dropped_any = 1'b0;
  endfunction

  always @(posedge clk_i) begin
    sorted_entry_t exp_e;
    if (rst_ni) begin
      // results first: a burst can never come out on the edge that closes its set
      if (result_ch.valid && result_ch.ready) begin
        if (sorted_q.size() == 0) begin
          $error("unexpected result: sorted_value %h last_out %b truncated %b",
                 result_ch.sorted_value, result_ch.last_out, result_ch.truncated);
          fail_count_o++;
        end else begin
          exp_e = sorted_q.pop_front();
          if (result_ch.sorted_value !== exp_e.value) begin
            $error("sorted_value: expected %h, got %h", exp_e.value, result_ch.sorted_value);
            fail_count_o++;
          end
          if (result_ch.last_out !== exp_e.last) begin
            $error("last_out: expected %b, got %b", exp_e.last, result_ch.last_out);
            fail_count_o++;
          end
          if (result_ch.truncated !== exp_e.trunc) begin
            $error("truncated: expected %b, got %b", exp_e.trunc, result_ch.truncated);
            fail_count_o++;
          end
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        if (held_count < DEPTH) begin
          held_values[held_count] = item_ch.value;
          held_count++;
        end else begin
          dropped_any = 1'b1;
        end
        if (item_ch.last) sort_held_set();
      end
      pending_o = sorted_q.size();
    end
  end

endmodule

### sim/tb_cocktail_shaker_sorter.sv
// Testbench top for the cocktail shaker sorter: clock, reset, stimulus and verdict.
// Depends on css_pkg, css_in_if, css_out_if, css_sort_checker and cocktail_shaker_sorter.
`timescale 1ns / 1ps

module tb_cocktail_shaker_sorter;
  import css_pkg::*;

  logic clk_i;
  logic rst_ni;

  css_in_if  item_ch ();
  css_out_if result_ch ();

  int fail_count;
  int pending;

  // idle odds in percent per cycle, changed per phase by the stimulus
  int send_idle_pct;
  int recv_idle_pct;
  // long receiver hold-off, consumed by the receiver process
  int rx_hold_cycles;
  int items_sent;

  cocktail_shaker_sorter dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_ch),
    .result_o(result_ch)
  );

  css_sort_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_ch     (item_ch),
    .result_ch   (result_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // 12 ns period
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Hard stop in case a transfer never completes.
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: ready changes only at the falling edge. A requested hold-off keeps
  // ready low for that many cycles, otherwise ready drops at the phase's odds.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        result_ch.ready = 1'b0;
        rx_hold_cycles--;
      end else begin
        result_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Values lean on the extremes and on duplicates, which are where sorting slips.
  function automatic value_t pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return value_t'($urandom_range(7));
      3:       return 32'h8000_0000 + value_t'($urandom_range(3)) - 32'd2;
      4:       return '1 - value_t'($urandom_range(3));
      default: return value_t'($urandom);
    endcase
  endfunction

  // One input transfer. Valid stays high from the previous transfer unless an idle
  // cycle is drawn, so back-to-back transfers never toggle valid within a step.
  task automatic offer_value(input value_t v, input logic is_last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid = 1'b0;
      item_ch.value = value_t'($urandom);
      item_ch.last  = 1'($urandom);
      @(negedge clk_i);
    end
    item_ch.valid = 1'b1;
    item_ch.value = v;
    item_ch.last  = is_last;
    do @(posedge clk_i); while (!item_ch.ready);
    items_sent++;
  endtask

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) offer_value(pick_value(), i == n - 1);
  endtask

  // Mostly short sets keep the sort cheap; a few fill or overflow the store.
  task automatic send_random_sets(input int item_goal);
    int r;
    while (items_sent < item_goal) begin
      r = $urandom_range(99);
      if (r < 60)      send_set($urandom_range(8, 1));
      else if (r < 85) send_set($urandom_range(20, 9));
      else if (r < 95) send_set($urandom_range(DEPTH, 21));
      else             send_set($urandom_range(DEPTH + 8, DEPTH + 1));
    end
  endtask

  // Sender pause: nothing offered until every queued result has come out.
  task automatic drain_all();
    @(negedge clk_i);
    item_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni         = 1'b0;
    item_ch.valid  = 1'b0;
    item_ch.value  = '0;
    item_ch.last   = 1'b0;
    send_idle_pct  = 9;
    recv_idle_pct  = 70;
    rx_hold_cycles = 0;
    items_sent     = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed sets: one-element sets at both extremes, reversed pair,
    // duplicates, a strictly descending run and an alternating run.
    offer_value('0, 1'b1);
    offer_value('1, 1'b1);
    offer_value('1, 1'b0);
    offer_value('0, 1'b1);
    offer_value(32'd5, 1'b0);
    offer_value(32'd5, 1'b0);
    offer_value(32'd1, 1'b1);
    for (int i = 6; i >= 0; i--) offer_value(value_t'(i) << 28, i == 0);
    offer_value(32'hAAAA_AAAA, 1'b0);
    offer_value(32'h5555_5555, 1'b0);
    offer_value(32'hAAAA_AAAA, 1'b0);
    offer_value(32'h5555_5555, 1'b1);

    // Store limits: exactly full, last arriving on the first dropped slot,
    // then an overflow by several.
    send_set(DEPTH);
    send_set(DEPTH + 1);
    send_set(DEPTH + 5);
    send_random_sets(150);
    drain_all();

    // Slow receiver flips to slow sender.
    send_idle_pct = 70;
    recv_idle_pct = 9;
    send_random_sets(270);
    drain_all();

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_sets(340);
    drain_all();

    // Long receiver hold-off while sets keep coming: the first full set sorts and
    // then cannot drain, so the block must stall its input.
    rx_hold_cycles = 2500;
    send_set(DEPTH);
    send_set(20);
    send_set(5);
    send_random_sets(400);
    drain_all();

    // let any stray result show up before the verdict
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### cocktail_shaker_sorter.f
+incdir+src
src/css_pkg.sv
src/css_in_if.sv
src/css_out_if.sv
src/css_dp.sv
src/css_ctrl.sv
src/cocktail_shaker_sorter.sv
sim/css_sort_checker.sv
sim/tb_cocktail_shaker_sorter.sv
